@@ src/i2cs_pkg.sv @@
// i2cs_pkg: shared codes and widths for the i2c master bit sequencer
// used by the channel interfaces and the top level, no dependencies
package i2cs_pkg;

    // request codes carried by req_type
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_START    = 3'd1;
    localparam logic [2:0] REQ_STOP     = 3'd2;
    localparam logic [2:0] REQ_WRITE    = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;
    localparam logic [2:0] REQ_WAIT_ACK = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_LONG_DELAY  = 2'd0;
    localparam logic [1:0] CFG_SHORT_DELAY = 2'd1;
    localparam logic [1:0] CFG_SETUP_DELAY = 2'd2;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DELAY_W    = 16;

    // reset values of the configuration registers
    localparam logic [15:0] LONG_DELAY_RST  = 16'd4;
    localparam logic [15:0] SHORT_DELAY_RST = 16'd2;
    localparam logic [15:0] SETUP_DELAY_RST = 16'd1;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

endpackage

@@ src/i2cs_ifs.sv @@
// i2cs channel interfaces: command ticks in, pin results out, register writes
// depends on i2cs_pkg
interface i2cs_cmd_if import i2cs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] write_byte;
    logic       ack_after_read;
    logic       sda_sample;

    modport source (output valid, req_type, write_byte, ack_after_read, sda_sample,
                    input ready);
    modport sink   (input valid, req_type, write_byte, ack_after_read, sda_sample,
                    output ready);
endinterface

interface i2cs_res_if import i2cs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_failed;

    modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, read_byte, ack_failed, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, read_byte, ack_failed, output ready);
endinterface

interface i2cs_cfg_if import i2cs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/i2c_master_bit_sequencer.sv @@
// i2c_master_bit_sequencer: tick-driven i2c master, one pin result per tick
// depends on i2cs_pkg and the channel interfaces in i2cs_ifs.sv
//
//  channel  | dir | transfer moves                                 | ready
//  i_cmd    | in  | req_type, write_byte, ack_after_read, sda_sample| result slot free
//  o_res    | out | scl/sda levels, drive enable, busy, done, data | from consumer
//  i_cfg    | in  | register index, write data                     | always high
//
// on every accepted tick the sequencer state and the result register load on
// the same edge, so a tick can follow in every cycle while i_cmd.ready is high
// a result waiting in the output register only stalls i_cmd when o_res.ready is low
// synchronous active-low reset returns the bus to idle with scl and sda high
// and the delay registers to their defaults
module i2c_master_bit_sequencer
    import i2cs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2cs_cmd_if.sink   i_cmd,
    i2cs_res_if.source o_res,
    i2cs_cfg_if.sink   i_cfg
);

    // sequencer phases
    typedef enum logic [13:0] {
        PH_IDLE    = 14'h0001,
        PH_ST_A    = 14'h0002,
        PH_ST_B    = 14'h0004,
        PH_SP_A    = 14'h0008,
        PH_SP_B    = 14'h0010,
        PH_SP_C    = 14'h0020,
        PH_WA_SET  = 14'h0040,
        PH_WA_POLL = 14'h0080,
        PH_WR_LOW  = 14'h0100,
        PH_WR_HIGH = 14'h0200,
        PH_RD_LOW  = 14'h0400,
        PH_RD_HIGH = 14'h0800,
        PH_AK_LOW  = 14'h1000,
        PH_AK_HIGH = 14'h2000
    } t_phase;

    // a zero delay behaves as one tick
    function automatic logic [DELAY_W-1:0] eff_delay(input logic [DELAY_W-1:0] d);
        return (d == '0) ? DELAY_W'(1) : d;
    endfunction

    // configuration registers
    logic [DELAY_W-1:0] r_long_delay;
    logic [DELAY_W-1:0] r_short_delay;
    logic [DELAY_W-1:0] r_setup_delay;
    logic [7:0]         r_ack_timeout;

    // sequencer state
    t_phase             r_phase,    n_phase;
    logic [DELAY_W-1:0] r_tick,     n_tick;
    logic [2:0]         r_bit,      n_bit;
    logic [7:0]         r_shift,    n_shift;
    logic [7:0]         r_poll,     n_poll;
    logic               r_scl,      n_scl;
    logic               r_sda,      n_sda;
    logic               r_sda_oe,   n_sda_oe;
    logic               r_ack_sel,  n_ack_sel;
    logic               r_fail,     n_fail;
    logic [7:0]         r_held,     n_held;
    logic               n_done;

    // result register
    logic               r_out_valid;
    logic               r_res_scl;
    logic               r_res_sda;
    logic               r_res_oe;
    logic               r_res_busy;
    logic               r_res_done;
    logic [7:0]         r_res_byte;
    logic               r_res_fail;

    logic               w_take;
    logic [DELAY_W-1:0] w_tick_dec;
    logic               w_expire;
    logic [7:0]         w_poll_base;
    logic [8:0]         w_poll_next;
    logic               w_poll_over;

    // a tick is taken whenever the result slot is free or being emptied
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_take      = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    assign w_tick_dec = (r_tick != '0) ? r_tick - DELAY_W'(1) : r_tick;
    assign w_expire   = (w_tick_dec == '0);

    // ack wait poll count: the first poll starts from zero
    assign w_poll_base = (r_phase == PH_WA_SET) ? 8'd0 : r_poll;
    assign w_poll_next = {1'b0, w_poll_base} + 9'd1;
    assign w_poll_over = (w_poll_next > {1'b0, r_ack_timeout});

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_poll    = r_poll;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_sda_oe  = r_sda_oe;
        n_ack_sel = r_ack_sel;
        n_fail    = r_fail;
        n_held    = r_held;
        n_done    = 1'b0;

        // timed phases count down one tick each
        if (r_phase != PH_IDLE && r_phase != PH_WA_POLL) begin
            n_tick = w_tick_dec;
        end

        case (r_phase)
            PH_IDLE: begin
                case (i_cmd.req_type)
                    REQ_START: begin
                        n_sda_oe = 1'b1;
                        n_sda    = 1'b1;
                        n_scl    = 1'b1;
                        n_phase  = PH_ST_A;
                        n_tick   = eff_delay(r_long_delay);
                    end
                    REQ_STOP: begin
                        n_sda_oe = 1'b1;
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                        n_phase  = PH_SP_A;
                        n_tick   = eff_delay(r_long_delay);
                    end
                    REQ_WRITE: begin
                        n_sda_oe = 1'b1;
                        n_shift  = i_cmd.write_byte;
                        n_bit    = 3'd0;
                        n_scl    = 1'b0;
                        n_sda    = i_cmd.write_byte[7];
                        n_phase  = PH_WR_LOW;
                        n_tick   = eff_delay(r_long_delay);
                    end
                    REQ_READ: begin
                        n_sda_oe  = 1'b0;
                        n_shift   = 8'd0;
                        n_bit     = 3'd0;
                        n_ack_sel = i_cmd.ack_after_read;
                        n_scl     = 1'b0;
                        n_phase   = PH_RD_LOW;
                        n_tick    = eff_delay(r_long_delay);
                    end
                    REQ_WAIT_ACK: begin
                        n_sda_oe = 1'b0;
                        n_sda    = 1'b1;
                        n_fail   = 1'b0;
                        n_phase  = PH_WA_SET;
                        n_tick   = eff_delay(r_setup_delay);
                    end
                    default: begin
                        // tick only, and unknown codes
                    end
                endcase
            end
            PH_ST_A: begin
                if (w_expire) begin
                    n_sda   = 1'b0;
                    n_phase = PH_ST_B;
                    n_tick  = eff_delay(r_long_delay);
                end
            end
            PH_ST_B: begin
                if (w_expire) begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            PH_SP_A: begin
                if (w_expire) begin
                    n_scl   = 1'b1;
                    n_phase = PH_SP_B;
                    n_tick  = eff_delay(r_short_delay);
                end
            end
            PH_SP_B: begin
                if (w_expire) begin
                    n_sda   = 1'b1;
                    n_phase = PH_SP_C;
                    n_tick  = eff_delay(r_long_delay);
                end
            end
            PH_SP_C: begin
                if (w_expire) begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            PH_WA_SET, PH_WA_POLL: begin
                // scl rises as polling starts, then one sample per tick
                if (r_phase == PH_WA_POLL || w_expire) begin
                    n_scl = 1'b1;
                    if (!i_cmd.sda_sample) begin
                        n_scl   = 1'b0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                        if (r_phase == PH_WA_SET) begin
                            n_poll = 8'd0;
                        end
                    end else if (w_poll_over) begin
                        // timed out: flag it and release the bus with a stop
                        n_poll   = w_poll_base;
                        n_fail   = 1'b1;
                        n_sda_oe = 1'b1;
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                        n_phase  = PH_SP_A;
                        n_tick   = eff_delay(r_long_delay);
                    end else begin
                        n_poll  = w_poll_next[7:0];
                        n_phase = PH_WA_POLL;
                    end
                end
            end
            PH_WR_LOW: begin
                if (w_expire) begin
                    n_scl   = 1'b1;
                    n_phase = PH_WR_HIGH;
                    n_tick  = eff_delay(r_short_delay);
                end
            end
            PH_WR_HIGH: begin
                if (w_expire) begin
                    if (r_bit != 3'd7) begin
                        n_bit   = r_bit + 3'd1;
                        n_scl   = 1'b0;
                        n_sda   = r_shift[~(r_bit + 3'd1)];
                        n_phase = PH_WR_LOW;
                        n_tick  = eff_delay(r_long_delay);
                    end else begin
                        n_scl   = 1'b0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            PH_RD_LOW: begin
                if (w_expire) begin
                    // sample on the rising scl edge
                    n_scl   = 1'b1;
                    n_shift = {r_shift[6:0], i_cmd.sda_sample};
                    n_phase = PH_RD_HIGH;
                    n_tick  = eff_delay(r_long_delay);
                end
            end
            PH_RD_HIGH: begin
                if (w_expire) begin
                    n_scl = 1'b0;
                    if (r_bit != 3'd7) begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_RD_LOW;
                        n_tick  = eff_delay(r_long_delay);
                    end else begin
                        n_sda_oe = 1'b1;
                        n_sda    = !r_ack_sel;
                        n_phase  = PH_AK_LOW;
                        n_tick   = r_ack_sel ? eff_delay(r_setup_delay)
                                             : eff_delay(r_short_delay);
                    end
                end
            end
            PH_AK_LOW: begin
                if (w_expire) begin
                    n_scl   = 1'b1;
                    n_phase = PH_AK_HIGH;
                    n_tick  = eff_delay(r_short_delay);
                end
            end
            PH_AK_HIGH: begin
                if (w_expire) begin
                    n_scl   = 1'b0;
                    n_held  = r_shift;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_delay  <= LONG_DELAY_RST;
            r_short_delay <= SHORT_DELAY_RST;
            r_setup_delay <= SETUP_DELAY_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LONG_DELAY:  r_long_delay  <= i_cfg.data;
                CFG_SHORT_DELAY: r_short_delay <= i_cfg.data;
                CFG_SETUP_DELAY: r_setup_delay <= i_cfg.data;
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_bit     <= 3'd0;
            r_shift   <= 8'd0;
            r_poll    <= 8'd0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_sda_oe  <= 1'b1;
            r_ack_sel <= 1'b0;
            r_fail    <= 1'b0;
            r_held    <= 8'd0;
        end else if (w_take) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_poll    <= n_poll;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_sda_oe  <= n_sda_oe;
            r_ack_sel <= n_ack_sel;
            r_fail    <= n_fail;
            r_held    <= n_held;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload shows the pins after this tick's update
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res_scl  <= n_scl;
            r_res_sda  <= n_sda;
            r_res_oe   <= n_sda_oe;
            r_res_busy <= (n_phase != PH_IDLE);
            r_res_done <= n_done;
            r_res_byte <= n_held;
            r_res_fail <= n_fail;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.scl_level        = r_res_scl;
    assign o_res.sda_level        = r_res_sda;
    assign o_res.sda_drive_enable = r_res_oe;
    assign o_res.busy_res         = r_res_busy;
    assign o_res.done_res         = r_res_done;
    assign o_res.read_byte        = r_res_byte;
    assign o_res.ack_failed       = r_res_fail;

endmodule
